// ===== rtl/rc_timer_resistance_meter_assert.svh =====
// Assertion macros for the RC timer resistance meter checkers.
// Included by the checker file; depends on nothing else.
`ifndef RC_TIMER_RESISTANCE_METER_ASSERT_SVH
`define RC_TIMER_RESISTANCE_METER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define RCTM_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define RCTM_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/rctm_pkg.sv =====
// Shared constants and types of the RC timer resistance meter.
// Used by the interfaces and every module of the block; depends on nothing.
`default_nettype none

package rctm_pkg;

  // Sizes of the measurement.
  localparam int AVG_DEPTH     = 50;
  localparam int DISCARD_PAIRS = 1;
  localparam int TIME_BITS     = 32;

  // Field widths.
  localparam int STAMP_W = 32;
  localparam int CH_W    = 4;
  localparam int RB_W    = 30;
  localparam int OUT_W   = 16;

  // Derived widths.
  localparam int FILL_W  = $clog2(AVG_DEPTH + 1);
  localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int TOTAL_W = TIME_BITS + FILL_W;
  localparam int NUM_W   = TOTAL_W + 1;
  localparam int P_W     = TOTAL_W + RB_W;
  localparam int DVD_W   = OUT_W + TOTAL_W + 2;
  localparam int REM_W   = TOTAL_W + 2;
  localparam int STEP_W  = $clog2(RB_W + 1);
  localparam int DISC_W  = ($clog2(DISCARD_PAIRS + 1) < 1) ? 1 : $clog2(DISCARD_PAIRS + 1);

  // Pair queue between the edge front end and the arithmetic back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values and limits.
  localparam logic [RB_W-1:0]  RB_RESET = RB_W'(10000);
  localparam logic [OUT_W-1:0] OUT_MAX  = {OUT_W{1'b1}};

  // One measured pair to be converted.
  typedef struct packed {
    logic [TIME_BITS-1:0] high_time;
    logic [TIME_BITS-1:0] low_time;
    logic [CH_W-1:0]      channel;
  } job_t;

  // Push side of the pair queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // Head of the pair queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

`default_nettype wire

// ===== rtl/rctm_if.sv =====
// Valid/ready channel interfaces of the RC timer resistance meter.
// Depends on rctm_pkg for the field widths.
`default_nettype none

// Timer edges coming in.
interface edge_if;
  logic                          valid;
  logic                          ready;
  logic                          edge_level;
  logic [rctm_pkg::STAMP_W-1:0]  edge_time;
  logic [rctm_pkg::CH_W-1:0]     channel;

  modport source (output valid, edge_level, edge_time, channel, input ready);
  modport sink   (input valid, edge_level, edge_time, channel, output ready);
endinterface

// Resistance results going out.
interface result_if;
  logic                        valid;
  logic                        ready;
  logic [rctm_pkg::OUT_W-1:0]  resistance;
  logic [rctm_pkg::CH_W-1:0]   result_channel;
  logic                        saturated;

  modport source (output valid, resistance, result_channel, saturated, input ready);
  modport sink   (input valid, resistance, result_channel, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/rctm_front.sv =====
// Edge front end: tracks channel switches, edge stamps and phase times, and
// pushes every usable high/low pair into the pair queue. Depends on rctm_pkg.
`default_nettype none

module rctm_front (
  input  logic            clk,
  input  logic            rst,
  edge_if.sink            edges,
  input  logic            queue_full,
  output rctm_pkg::push_t push
);

  logic                             rise_seen;
  logic                             fall_seen;
  logic                             low_measured;
  logic [rctm_pkg::DISC_W-1:0]      discard_left;
  logic [rctm_pkg::CH_W-1:0]        prev_channel;
  logic                             prev_valid;
  logic [rctm_pkg::TIME_BITS-1:0]   rise_stamp;
  logic [rctm_pkg::TIME_BITS-1:0]   fall_stamp;
  logic [rctm_pkg::TIME_BITS-1:0]   low_time;

  logic                             accept;
  logic                             switched;
  logic                             rise_seen_c;
  logic                             fall_seen_c;
  logic                             low_meas_c;
  logic [rctm_pkg::DISC_W-1:0]      discard_c;
  logic [rctm_pkg::DISC_W-1:0]      discard_next;
  logic                             low_meas_next;
  logic [rctm_pkg::TIME_BITS-1:0]   stamp;
  logic [rctm_pkg::TIME_BITS-1:0]   high_new;
  logic                             pair;

  // An edge is taken whenever the queue can hold a pair.
  assign edges.ready = !queue_full;
  assign accept      = edges.valid && edges.ready;
  assign stamp       = edges.edge_time[rctm_pkg::TIME_BITS-1:0];

  // A channel switch clears the capture state before the edge is used.
  always_comb begin
    switched    = !prev_valid || (edges.channel != prev_channel);
    rise_seen_c = switched ? 1'b0 : rise_seen;
    fall_seen_c = switched ? 1'b0 : fall_seen;
    low_meas_c  = switched ? 1'b0 : low_measured;
    discard_c   = switched ? rctm_pkg::DISC_W'(rctm_pkg::DISCARD_PAIRS) : discard_left;
  end

  // A falling edge closing a high phase after a measured low phase is a pair.
  always_comb begin
    high_new      = stamp - rise_stamp;
    pair          = accept && !edges.edge_level && rise_seen_c && low_meas_c;
    low_meas_next = low_meas_c || (edges.edge_level && fall_seen_c);
    discard_next  = discard_c;
    if (pair && (discard_c != '0)) begin
      discard_next = discard_c - rctm_pkg::DISC_W'(1);
    end
    push.valid          = pair && (discard_c == '0) && (high_new != '0) && (low_time != '0);
    push.job.high_time  = high_new;
    push.job.low_time   = low_time;
    push.job.channel    = edges.channel;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_seen    <= 1'b0;
      fall_seen    <= 1'b0;
      low_measured <= 1'b0;
      discard_left <= rctm_pkg::DISC_W'(rctm_pkg::DISCARD_PAIRS);
      prev_channel <= '0;
      prev_valid   <= 1'b0;
    end else if (accept) begin
      rise_seen    <= rise_seen_c || edges.edge_level;
      fall_seen    <= fall_seen_c || !edges.edge_level;
      low_measured <= low_meas_next;
      discard_left <= discard_next;
      prev_channel <= edges.channel;
      prev_valid   <= 1'b1;
    end
  end

  // Stamps and the low phase time; they are only read behind their seen marks.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (edges.edge_level) begin
        rise_stamp <= stamp;
        if (fall_seen_c) begin
          low_time <= stamp - fall_stamp;
        end
      end else begin
        fall_stamp <= stamp;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rctm_queue.sv =====
// Short pair queue that decouples the edge front end from the back end.
// Depends on rctm_pkg for the job type and depth.
`default_nettype none

module rctm_queue (
  input  logic            clk,
  input  logic            rst,
  input  rctm_pkg::push_t push,
  input  logic            pop,
  output rctm_pkg::head_t head,
  output logic            full
);

  rctm_pkg::job_t                 slots [rctm_pkg::QUEUE_DEPTH];
  logic [rctm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rctm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rctm_pkg::QCNT_W-1:0]    count;
  logic                           do_pop;

  assign full       = (count == rctm_pkg::QCNT_W'(rctm_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == rctm_pkg::QPTR_W'(rctm_pkg::QUEUE_DEPTH - 1)) ? '0
                  : wr_ptr + rctm_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rctm_pkg::QPTR_W'(rctm_pkg::QUEUE_DEPTH - 1)) ? '0
                  : rd_ptr + rctm_pkg::QPTR_W'(1);
      end
      if (push.valid && !do_pop) begin
        count <= count + rctm_pkg::QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
        count <= count - rctm_pkg::QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rctm_back.sv =====
// Arithmetic back end: keeps the low-time history and its running total,
// then works out rb*(high*count - total)/total with a shift-add multiplier
// and a restoring divider. Depends on rctm_pkg and the result interface.
`default_nettype none

module rctm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rctm_pkg::RB_W-1:0]    cfg_wdata,
  input  rctm_pkg::head_t              head,
  output logic                         pop,
  result_if.source                     results
);

  localparam int TW  = rctm_pkg::TOTAL_W;
  localparam int NW  = rctm_pkg::NUM_W;
  localparam int PW  = rctm_pkg::P_W;
  localparam int DW  = rctm_pkg::DVD_W;
  localparam int RW  = rctm_pkg::REM_W;
  localparam int OW  = rctm_pkg::OUT_W;
  localparam int SW  = rctm_pkg::STEP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HIST = 3'd1;
  localparam logic [2:0] S_PROD = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                       state;
  logic [rctm_pkg::RB_W-1:0]        rb;
  logic [TW-1:0]                    total;
  logic [rctm_pkg::SLOT_W-1:0]      slot;
  logic [rctm_pkg::FILL_W-1:0]      fill;
  logic [rctm_pkg::TIME_BITS-1:0]   history [rctm_pkg::AVG_DEPTH];
  logic [rctm_pkg::TIME_BITS-1:0]   hist_rdata;
  rctm_pkg::job_t                   job;
  logic [TW-1:0]                    prod;
  logic [PW-1:0]                    mcand;
  logic [rctm_pkg::RB_W-1:0]        mplier;
  logic [PW-1:0]                    acc;
  logic [RW-1:0]                    rem;
  logic [OW-1:0]                    dvd_lo;
  logic [SW-1:0]                    step;
  logic [OW-1:0]                    res;
  logic                             sat;
  logic                             out_valid;
  logic [OW-1:0]                    out_res;
  logic [rctm_pkg::CH_W-1:0]        out_ch;
  logic                             out_sat;

  logic [rctm_pkg::TIME_BITS-1:0]   old_low;
  logic [NW-1:0]                    num;
  logic [PW-1:0]                    limit;
  logic [DW-1:0]                    dvd;
  logic [RW-1:0]                    divisor;
  logic [RW-1:0]                    trial;
  logic                             qbit;

  // Output register.
  assign results.valid          = out_valid;
  assign results.resistance     = out_res;
  assign results.result_channel = out_ch;
  assign results.saturated      = out_sat;

  assign pop = (state == S_IDLE) && head.valid;

  // Datapath terms of the individual steps.
  always_comb begin
    old_low = (fill == rctm_pkg::FILL_W'(rctm_pkg::AVG_DEPTH)) ? hist_rdata : '0;
    num     = {1'b0, prod} - {1'b0, total};
    limit   = (PW'(total) << OW) - PW'(total);
    dvd     = {acc[DW-2:0], 1'b0} + DW'(total);
    divisor = {1'b0, total, 1'b0};
    trial   = {rem[RW-2:0], dvd_lo[OW-1]};
    qbit    = (trial >= divisor);
  end

  // History memory: registered read at the write slot, written once per pair.
  always_ff @(posedge clk) begin
    hist_rdata <= history[slot];
    if (state == S_HIST) begin
      history[slot] <= job.low_time;
    end
  end

  // Sequencer, average bookkeeping and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rb        <= rctm_pkg::RB_RESET;
      total     <= '0;
      slot      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register fills when it is free and empties when the sink takes the beat.
      if ((state == S_OUT) && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            state <= S_HIST;
          end
        end
        S_HIST: begin
          state <= S_PROD;
        end
        S_PROD: begin
          state <= S_NUM;
        end
        S_NUM: begin
          if ((rb == '0) || (num == '0) || num[NW-1]) begin
            state <= S_OUT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == SW'(1)) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= (acc > limit) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (step == SW'(1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Writing the resistor value restarts the average; otherwise a pair enters it.
      if (cfg_we) begin
        rb    <= cfg_wdata;
        total <= '0;
        slot  <= '0;
        fill  <= '0;
      end else if (state == S_HIST) begin
        total <= total - TW'(old_low) + TW'(job.low_time);
        slot  <= (slot == rctm_pkg::SLOT_W'(rctm_pkg::AVG_DEPTH - 1)) ? '0
                 : slot + rctm_pkg::SLOT_W'(1);
        if (fill != rctm_pkg::FILL_W'(rctm_pkg::AVG_DEPTH)) begin
          fill <= fill + rctm_pkg::FILL_W'(1);
        end
      end
    end
  end

  // Arithmetic registers of the multiply and divide steps.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job <= head.job;
      end
      S_PROD: begin
        prod <= TW'(job.high_time) * TW'(fill);
      end
      S_NUM: begin
        // A zero resistor gives zero without the saturation mark.
        res    <= '0;
        sat    <= num[NW-1] && (rb != '0);
        mcand  <= PW'(num[TW-1:0]);
        mplier <= rb;
        acc    <= '0;
        step   <= SW'(rctm_pkg::RB_W);
      end
      S_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        step   <= step - SW'(1);
      end
      S_CMP: begin
        res    <= rctm_pkg::OUT_MAX;
        sat    <= (acc > limit);
        rem    <= dvd[DW-1:OW];
        dvd_lo <= dvd[OW-1:0];
        step   <= SW'(OW);
      end
      S_DIV: begin
        rem    <= qbit ? (trial - divisor) : trial;
        dvd_lo <= dvd_lo << 1;
        res    <= {res[OW-2:0], qbit};
        step   <= step - SW'(1);
      end
      S_OUT: begin
        if (!out_valid || results.ready) begin
          out_res <= res;
          out_ch  <= job.channel;
          out_sat <= sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rc_timer_resistance_meter.sv =====
// Top level of the RC timer resistance meter.
// Depends on rctm_pkg, rctm_if, rctm_front, rctm_queue and rctm_back.
`default_nettype none

// The block takes one timer edge per cycle into a front end that tracks the
// capture state and hands each usable high/low pair to a two-entry queue, so
// edges keep flowing while a pair is being converted. The back end converts
// one pair at a time: it takes the pair from the queue, updates the low-time
// history and forms high*count - total, then runs a shift-add multiply by the
// resistor value, a compare step and a restoring divide before handing the
// result to the output register. A pair whose result is zero or negative, or
// taken with a zero resistor, skips the multiply and divide, and one that
// saturates at the top skips the divide. The shared multiply and divide loop
// sets the pair rate. Edges stall only when two pairs are already queued. The
// low-time history needs no clearing pass after reset or after a write of the
// resistor register: a fill count marks which entries hold data.
module rc_timer_resistance_meter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rctm_pkg::RB_W-1:0]  cfg_wdata,
  edge_if.sink                       edges,
  result_if.source                   results
);

  rctm_pkg::push_t push;
  rctm_pkg::head_t head;
  logic            queue_full;
  logic            pop;

  // Edge tracking.
  rctm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .edges      (edges),
    .queue_full (queue_full),
    .push       (push)
  );

  // Pair queue.
  rctm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (queue_full)
  );

  // Average and resistance arithmetic.
  rctm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .results   (results)
  );

endmodule

`default_nettype wire

// ===== rtl/rctm_checker.sv =====
// Port-level checker of the RC timer resistance meter and its bind.
// Depends on rctm_pkg and the macros in rc_timer_resistance_meter_assert.svh.
`default_nettype none

`include "rc_timer_resistance_meter_assert.svh"

module rctm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rctm_pkg::OUT_W-1:0]  out_resistance,
  input logic [rctm_pkg::CH_W-1:0]   out_channel,
  input logic                        out_saturated
);

  // A result waiting on the sink stays offered.
  `RCTM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `RCTM_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_resistance) && $stable(out_channel) && $stable(out_saturated), "stalled result changed")

  // Reset empties the output register.
  `RCTM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result offered after reset")

  // A saturated result sits at one of the two rails.
  `RCTM_ASSERT(a_sat_rail, clk, rst, out_valid && out_saturated |-> (out_resistance == '0) || (out_resistance == rctm_pkg::OUT_MAX), "saturated result off the rails")

endmodule

bind rc_timer_resistance_meter rctm_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_resistance (results.resistance),
  .out_channel    (results.result_channel),
  .out_saturated  (results.saturated)
);

`default_nettype wire
